[hw/rtl/indexed_priority_heap_core_macros.svh]
// assertion macros for the indexed priority heap core
// no dependencies; define SYNTH to drop the checks
`ifndef INDEXED_PRIORITY_HEAP_CORE_MACROS_SVH
`define INDEXED_PRIORITY_HEAP_CORE_MACROS_SVH
`ifndef SYNTH
`define IPH_AST_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("heap core check failed");
`define IPH_AST_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("heap core check failed");
`else
`define IPH_AST_NOW(label, clk, rst_n, ante, cons)
`define IPH_AST_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[hw/rtl/iph_pkg.sv]
// shared codes and controller/datapath link types for the heap core
// no dependencies
`timescale 1ns / 1ps
package iph_pkg;
	localparam logic [1:0] MODE_INSERT  = 2'd0;
	localparam logic [1:0] MODE_EXTRACT = 2'd1;
	localparam logic [1:0] MODE_REPLACE = 2'd2;
	localparam logic [1:0] MODE_QUERY   = 2'd3;

	localparam logic [2:0] ST_OK     = 3'd0;
	localparam logic [2:0] ST_EMPTY  = 3'd1;
	localparam logic [2:0] ST_FULL   = 3'd2;
	localparam logic [2:0] ST_DUP    = 3'd3;
	localparam logic [2:0] ST_ABSENT = 3'd4;

	typedef struct packed {
		logic       clear;
		logic       load;
		logic       probe_new;
		logic       probe_heap;
		logic       start_insert;
		logic       start_replace;
		logic       ext_rd0;
		logic       ext_top;
		logic       ext_last;
		logic       up_rd;
		logic       up_move;
		logic       dn_rd_l;
		logic       dn_take_l;
		logic       dn_take_r;
		logic       dn_move;
		logic       place;
		logic       emit;
		logic [2:0] status;
		logic       found;
		logic       use_top;
	} iph_cmd_t;

	typedef struct packed {
		logic       clr_last;
		logic       present;
		logic       full;
		logic       empty;
		logic       same_key;
		logic       pos_zero;
		logic       up_wins;
		logic       lc_out;
		logic       rc_out;
		logic       child_wins;
		logic       out_busy;
		logic [1:0] mode;
	} iph_stat_t;
endpackage

[hw/rtl/iph_ifs.sv]
// request, response and order-register channels of the heap core
// no dependencies
`timescale 1ns / 1ps
interface iph_req_if #(parameter int KEY_BITS = 10);
	logic                valid;
	logic                ready;
	logic [1:0]          mode;
	logic [KEY_BITS-1:0] key;
	logic [KEY_BITS-1:0] new_key;
	modport source(output valid, mode, key, new_key, input ready);
	modport sink(input valid, mode, key, new_key, output ready);
endinterface

interface iph_rsp_if #(parameter int KEY_BITS = 10, parameter int COUNT_BITS = 7);
	logic                  valid;
	logic                  ready;
	logic [2:0]            status;
	logic [KEY_BITS-1:0]   top_key;
	logic                  found;
	logic [COUNT_BITS-1:0] count;
	modport source(output valid, status, top_key, found, count, input ready);
	modport sink(input valid, status, top_key, found, count, output ready);
endinterface

interface iph_cfg_if;
	logic valid;
	logic ready;
	logic max_first;
	modport source(output valid, max_first, input ready);
	modport sink(input valid, max_first, output ready);
endinterface

[hw/rtl/iph_datapath.sv]
// heap datapath: heap slot memory, key-to-slot memory, sift registers, result register
// depends on iph_pkg
`timescale 1ns / 1ps
module iph_datapath import iph_pkg::*; #(
	parameter int CAPACITY = 64,
	parameter int KEY_BITS = 10
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  iph_cmd_t                            cmd,
	output iph_stat_t                           stat,
	input  logic [1:0]                          in_mode,
	input  logic [KEY_BITS-1:0]                 in_key,
	input  logic [KEY_BITS-1:0]                 in_new_key,
	input  logic                                cfg_we,
	input  logic                                cfg_max_first,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [2:0]                          out_status,
	output logic [KEY_BITS-1:0]                 out_top_key,
	output logic                                out_found,
	output logic [$clog2(CAPACITY+1)-1:0]       out_count
);
	localparam int PW   = $clog2(CAPACITY);
	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int IW   = CW + 1;
	localparam int KEYS = 1 << KEY_BITS;

	logic [KEY_BITS-1:0] heap_mem [CAPACITY];
	logic [PW-1:0]       pos_mem [KEYS];

	logic [1:0]          mode_q;
	logic [KEY_BITS-1:0] key_q, nkey_q, probe_q, mv_q, child_q, top_q, heap_rd_q;
	logic [PW-1:0]       slot_q, pos_q, child_pos_q, pos_rd_q;
	logic [CW-1:0]       fill_q;
	logic [KEY_BITS-1:0] clr_q;
	logic                max_first_q;
	logic                out_valid_q;

	logic [IW-1:0]       lc, rc;
	logic [PW-1:0]       parent, last_idx;
	logic                heap_re, heap_we, pos_re, pos_we;
	logic [PW-1:0]       heap_raddr, heap_waddr, pos_wdata;
	logic [KEY_BITS-1:0] heap_wdata, pos_raddr, pos_waddr;

	function automatic logic ranks(input logic mf, input logic [KEY_BITS-1:0] a,
		input logic [KEY_BITS-1:0] b);
		ranks = mf ? (a > b) : (a < b);
	endfunction

	assign lc       = IW'({pos_q, 1'b1});
	assign rc       = lc + IW'(1);
	assign parent   = PW'((pos_q - PW'(1)) >> 1);
	assign last_idx = PW'(fill_q - CW'(1));

	always_comb begin
		stat.clr_last   = clr_q == '1;
		stat.present    = (CW'(slot_q) < fill_q) && (heap_rd_q == probe_q);
		stat.full       = fill_q == CW'(CAPACITY);
		stat.empty      = fill_q == '0;
		stat.same_key   = key_q == nkey_q;
		stat.pos_zero   = pos_q == '0;
		stat.up_wins    = ranks(max_first_q, mv_q, heap_rd_q);
		stat.lc_out     = lc >= IW'(fill_q);
		stat.rc_out     = rc >= IW'(fill_q);
		stat.child_wins = ranks(max_first_q, child_q, mv_q);
		stat.out_busy   = out_valid_q && !out_ready;
		stat.mode       = mode_q;
	end

	always_comb begin
		heap_re    = 1'b1;
		heap_raddr = '0;
		if (cmd.probe_heap) begin
			heap_raddr = pos_rd_q;
		end else if (cmd.ext_top) begin
			heap_raddr = last_idx;
		end else if (cmd.up_rd) begin
			heap_raddr = parent;
		end else if (cmd.dn_rd_l) begin
			heap_raddr = lc[PW-1:0];
		end else if (cmd.dn_take_l) begin
			heap_raddr = rc[PW-1:0];
		end else begin
			heap_re = cmd.ext_rd0;
		end
		heap_we    = cmd.up_move || cmd.dn_move || cmd.place;
		heap_waddr = pos_q;
		pos_wdata  = cmd.clear ? '0 : pos_q;
		if (cmd.up_move) begin
			heap_wdata = heap_rd_q;
		end else if (cmd.dn_move) begin
			heap_wdata = child_q;
		end else begin
			heap_wdata = mv_q;
		end
		pos_waddr = cmd.clear ? clr_q : heap_wdata;
		pos_we    = heap_we || cmd.clear;
		pos_re    = cmd.load || cmd.probe_new;
		pos_raddr = cmd.load ? in_key : nkey_q;
	end

	always_ff @(posedge clk) begin
		if (heap_re) begin
			heap_rd_q <= heap_mem[heap_raddr];
		end
		if (heap_we) begin
			heap_mem[heap_waddr] <= heap_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (pos_re) begin
			pos_rd_q <= pos_mem[pos_raddr];
		end
		if (pos_we) begin
			pos_mem[pos_waddr] <= pos_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q  <= in_mode;
			key_q   <= in_key;
			nkey_q  <= in_new_key;
			probe_q <= in_key;
		end
		if (cmd.probe_heap) begin
			slot_q <= pos_rd_q;
		end
		if (cmd.probe_new) begin
			probe_q <= nkey_q;
			pos_q   <= slot_q;
		end
		if (cmd.start_insert) begin
			pos_q <= PW'(fill_q);
			mv_q  <= key_q;
		end
		if (cmd.start_replace) begin
			mv_q <= nkey_q;
		end
		if (cmd.ext_top) begin
			top_q <= heap_rd_q;
		end
		if (cmd.ext_last) begin
			mv_q  <= heap_rd_q;
			pos_q <= '0;
		end
		if (cmd.up_move) begin
			pos_q <= parent;
		end
		if (cmd.dn_take_l) begin
			child_q     <= heap_rd_q;
			child_pos_q <= lc[PW-1:0];
		end
		if (cmd.dn_take_r && !ranks(max_first_q, child_q, heap_rd_q)) begin
			child_q     <= heap_rd_q;
			child_pos_q <= rc[PW-1:0];
		end
		if (cmd.dn_move) begin
			pos_q <= child_pos_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			clr_q       <= '0;
			max_first_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clear) begin
				clr_q <= clr_q + KEY_BITS'(1);
			end
			if (cmd.start_insert) begin
				fill_q <= fill_q + CW'(1);
			end else if (cmd.ext_last) begin
				fill_q <= fill_q - CW'(1);
			end
			if (cfg_we) begin
				max_first_q <= cfg_max_first;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_status  <= cmd.status;
			out_top_key <= cmd.use_top ? top_q : '0;
			out_found   <= cmd.found;
			out_count   <= fill_q;
		end
	end

	assign out_valid = out_valid_q;
endmodule

[hw/rtl/iph_ctrl.sv]
// heap controller: request decode, membership probes, sift-up and sift-down sequencing
// depends on iph_pkg
`timescale 1ns / 1ps
module iph_ctrl import iph_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  iph_stat_t stat,
	output iph_cmd_t  cmd
);
	typedef enum logic [13:0] {
		S_IDLE   = 14'b00000000000001,
		S_P1     = 14'b00000000000010,
		S_P2     = 14'b00000000000100,
		S_E2     = 14'b00000000001000,
		S_E3     = 14'b00000000010000,
		S_UP_RD  = 14'b00000000100000,
		S_UP_CMP = 14'b00000001000000,
		S_DN_L   = 14'b00000010000000,
		S_DN_LD  = 14'b00000100000000,
		S_DN_RD  = 14'b00001000000000,
		S_DN_CMP = 14'b00010000000000,
		S_WRITE  = 14'b00100000000000,
		S_OUT    = 14'b01000000000000,
		S_CLR    = 14'b10000000000000
	} state_t;

	state_t     state_q, state_d;
	logic [2:0] res_q, res_d;
	logic       found_q, found_d, top_sel_q, top_sel_d, second_q, second_d;

	assign req_ready = state_q == S_IDLE;

	always_comb begin
		cmd         = '0;
		cmd.status  = res_q;
		cmd.found   = found_q;
		cmd.use_top = top_sel_q;
		state_d     = state_q;
		res_d       = res_q;
		found_d     = found_q;
		top_sel_d   = top_sel_q;
		second_d    = second_q;
		case (state_q)
			S_CLR: begin
				cmd.clear = 1'b1;
				if (stat.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req_valid) begin
					cmd.load  = 1'b1;
					res_d     = ST_OK;
					found_d   = 1'b0;
					top_sel_d = 1'b0;
					second_d  = 1'b0;
					state_d   = S_P1;
				end
			end
			S_P1: begin
				if (stat.mode == MODE_EXTRACT) begin
					if (stat.empty) begin
						res_d   = ST_EMPTY;
						state_d = S_OUT;
					end else begin
						cmd.ext_rd0 = 1'b1;
						state_d     = S_E2;
					end
				end else begin
					cmd.probe_heap = 1'b1;
					state_d        = S_P2;
				end
			end
			S_P2: begin
				state_d = S_OUT;
				if (stat.mode == MODE_INSERT) begin
					if (stat.present) begin
						res_d = ST_DUP;
					end else if (stat.full) begin
						res_d = ST_FULL;
					end else begin
						cmd.start_insert = 1'b1;
						state_d          = S_UP_RD;
					end
				end else if (stat.mode == MODE_REPLACE) begin
					if (second_q) begin
						if (stat.present) begin
							res_d = ST_DUP;
						end else begin
							cmd.start_replace = 1'b1;
							state_d           = S_UP_RD;
						end
					end else if (!stat.present) begin
						res_d = ST_ABSENT;
					end else if (!stat.same_key) begin
						cmd.probe_new = 1'b1;
						second_d      = 1'b1;
						state_d       = S_P1;
					end
				end else begin
					found_d = stat.present;
				end
			end
			S_E2: begin
				cmd.ext_top = 1'b1;
				state_d     = S_E3;
			end
			S_E3: begin
				cmd.ext_last = 1'b1;
				top_sel_d    = 1'b1;
				state_d      = S_DN_L;
			end
			S_UP_RD: begin
				if (stat.pos_zero) begin
					state_d = S_DN_L;
				end else begin
					cmd.up_rd = 1'b1;
					state_d   = S_UP_CMP;
				end
			end
			S_UP_CMP: begin
				if (stat.up_wins) begin
					cmd.up_move = 1'b1;
					state_d     = S_UP_RD;
				end else begin
					state_d = S_DN_L;
				end
			end
			S_DN_L: begin
				if (stat.lc_out) begin
					state_d = S_WRITE;
				end else begin
					cmd.dn_rd_l = 1'b1;
					state_d     = S_DN_LD;
				end
			end
			S_DN_LD: begin
				cmd.dn_take_l = 1'b1;
				state_d       = stat.rc_out ? S_DN_CMP : S_DN_RD;
			end
			S_DN_RD: begin
				cmd.dn_take_r = 1'b1;
				state_d       = S_DN_CMP;
			end
			S_DN_CMP: begin
				if (stat.child_wins) begin
					cmd.dn_move = 1'b1;
					state_d     = S_DN_L;
				end else begin
					state_d = S_WRITE;
				end
			end
			S_WRITE: begin
				cmd.place = 1'b1;
				state_d   = S_OUT;
			end
			S_OUT: begin
				if (!stat.out_busy) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLR;
			res_q     <= ST_OK;
			found_q   <= 1'b0;
			top_sel_q <= 1'b0;
			second_q  <= 1'b0;
		end else begin
			state_q   <= state_d;
			res_q     <= res_d;
			found_q   <= found_d;
			top_sel_q <= top_sel_d;
			second_q  <= second_d;
		end
	end
endmodule

[hw/rtl/indexed_priority_heap_core.sv]
// Indexed binary heap of unique keys with a key-to-slot table. One request at a time: query,
// duplicate and full/empty cases go from the decode and probe states to the response; an
// insert, extract or replace also steps through S_UP_RD and S_UP_CMP per level moved up and
// through S_DN_L, S_DN_LD, S_DN_RD (when a right child exists) and S_DN_CMP per level moved
// down, both bounded by log2(CAPACITY). The sequencing is set by the single read port of the
// heap slot memory with registered read data. Membership is derived from the slot table and
// heap contents. After reset a clearing pass zeroes every slot table entry before the first
// request is taken. The order register may be written only while no request is in flight.
`timescale 1ns / 1ps
`include "indexed_priority_heap_core_macros.svh"
module indexed_priority_heap_core import iph_pkg::*; #(
	parameter int CAPACITY = 64,
	parameter int KEY_BITS = 10
) (
	input  logic clk,
	input  logic arst_n,
	iph_req_if.sink   req,
	iph_rsp_if.source rsp,
	iph_cfg_if.sink   cfg
);
	iph_cmd_t  cmd;
	iph_stat_t stat;

	assign cfg.ready = 1'b1;

	iph_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	iph_datapath #(
		.CAPACITY (CAPACITY),
		.KEY_BITS (KEY_BITS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.in_mode       (req.mode),
		.in_key        (req.key),
		.in_new_key    (req.new_key),
		.cfg_we        (cfg.valid),
		.cfg_max_first (cfg.max_first),
		.out_valid     (rsp.valid),
		.out_ready     (rsp.ready),
		.out_status    (rsp.status),
		.out_top_key   (rsp.top_key),
		.out_found     (rsp.found),
		.out_count     (rsp.count)
	);

	`IPH_AST_NEXT(a_one_at_a_time, clk, arst_n, req.valid && req.ready, !req.ready)
	`IPH_AST_NOW(a_count_bound, clk, arst_n, rsp.valid, rsp.count <= CAPACITY)
	`IPH_AST_NOW(a_full_count, clk, arst_n, rsp.valid && rsp.status == ST_FULL, rsp.count == CAPACITY)
	`IPH_AST_NOW(a_empty_result, clk, arst_n, rsp.valid && rsp.status == ST_EMPTY, rsp.count == 0 && rsp.top_key == 0)
endmodule

[sim/iph_checker.sv]
// predictor and result checker for the indexed priority heap core
// depends on iph_pkg and the request, response and order channels in iph_ifs
`timescale 1ns / 1ps
module iph_checker import iph_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	iph_req_if    req,
	iph_rsp_if    rsp,
	iph_cfg_if    cfg,
	output int    fails,
	output int    pending
);
	localparam int SLOTS = 64;

	typedef struct packed {
		logic [2:0] status;
		logic [9:0] top_key;
		logic       found;
		logic [6:0] count;
	} heap_rsp_t;

	logic [9:0] heap_keys [SLOTS];
	logic [5:0] key_slot  [1024];
	logic       held      [1024];
	int         held_cnt;
	logic       largest_first;
	heap_rsp_t  due_q [$];

	function automatic logic outranks(logic [9:0] a, logic [9:0] b);
		return largest_first ? (a > b) : (a < b);
	endfunction

	task automatic swap_slots(int p, int q);
		logic [9:0] kp, kq;
		kp = heap_keys[p];
		kq = heap_keys[q];
		heap_keys[p] = kq;
		heap_keys[q] = kp;
		key_slot[kq] = 6'(p);
		key_slot[kp] = 6'(q);
	endtask

	task automatic sift(int pos);
		int up, lc, rc, pick;
		while (pos > 0) begin
			up = (pos - 1) / 2;
			if (!outranks(heap_keys[pos], heap_keys[up])) break;
			swap_slots(pos, up);
			pos = up;
		end
		forever begin
			lc = 2 * pos + 1;
			rc = lc + 1;
			if (lc >= held_cnt) break;
			pick = (rc >= held_cnt || outranks(heap_keys[lc], heap_keys[rc])) ? lc : rc;
			if (!outranks(heap_keys[pick], heap_keys[pos])) break;
			swap_slots(pos, pick);
			pos = pick;
		end
	endtask

	task automatic predict(logic [1:0] mode, logic [9:0] k, logic [9:0] nk);
		heap_rsp_t r;
		int pos;
		r = '0;
		r.status = ST_OK;
		case (mode)
			MODE_INSERT: begin
				if (held[k]) r.status = ST_DUP;
				else if (held_cnt >= SLOTS) r.status = ST_FULL;
				else begin
					pos = held_cnt;
					heap_keys[pos] = k;
					key_slot[k] = 6'(pos);
					held[k] = 1'b1;
					held_cnt++;
					sift(pos);
				end
			end
			MODE_EXTRACT: begin
				if (held_cnt == 0) r.status = ST_EMPTY;
				else begin
					swap_slots(0, held_cnt - 1);
					held_cnt--;
					r.top_key = heap_keys[held_cnt];
					held[r.top_key] = 1'b0;
					sift(0);
				end
			end
			MODE_REPLACE: begin
				if (!held[k]) r.status = ST_ABSENT;
				else if (nk != k) begin
					if (held[nk]) r.status = ST_DUP;
					else begin
						pos = int'(key_slot[k]);
						if (pos >= held_cnt) pos = 0;
						held[k] = 1'b0;
						held[nk] = 1'b1;
						key_slot[nk] = 6'(pos);
						heap_keys[pos] = nk;
						sift(pos);
					end
				end
			end
			default: r.found = held[k];
		endcase
		r.count = held_cnt[6:0];
		due_q.push_back(r);
	endtask

	initial begin
		held_cnt = 0;
		largest_first = 1'b0;
		foreach (held[i]) held[i] = 1'b0;
	end

	always @(posedge clk) begin
		heap_rsp_t want, got;
		if (!arst_n) begin
			fails = 0;
		end else begin
			if (cfg.valid && cfg.ready) largest_first = cfg.max_first;
			if (req.valid && req.ready) predict(req.mode, req.key, req.new_key);
			if (rsp.valid && rsp.ready) begin
				got = {rsp.status, rsp.top_key, rsp.found, rsp.count};
				if (due_q.size() == 0) begin
					fails++;
					if (fails <= 10) $display("unexpected response %p", got);
				end else begin
					want = due_q.pop_front();
					if (got !== want) begin
						fails++;
						if (fails <= 10)
							$display("mismatch: expected %p actual %p", want, got);
					end
				end
			end
		end
		pending = due_q.size();
	end
endmodule

[sim/indexed_priority_heap_core_tb.sv]
// stimulus and verdict for the indexed priority heap core
// depends on iph_pkg, iph_ifs, iph_checker and the core itself
`timescale 1ns / 1ps
module indexed_priority_heap_core_tb import iph_pkg::*;;
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   fails, pending;
	int   hold_req = 0;
	int   quiet = 0;
	logic [9:0] pool [128];

	iph_req_if req();
	iph_rsp_if rsp();
	iph_cfg_if cfg();

	indexed_priority_heap_core dut (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp), .cfg(cfg));
	iph_checker chk (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp), .cfg(cfg),
		.fails(fails), .pending(pending));

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// receiver stall pattern plus a single long hold of the response ready low
	always @(negedge clk) begin
		int window, style;
		bit hold_done;
		if (hold_req > 0 && !hold_done) begin
			hold_done = 1'b1;
			rsp.ready <= 1'b0;
			repeat (hold_req) @(negedge clk);
		end else begin
			if (window == 0) begin
				window = $urandom_range(10, 80);
				style = $urandom_range(0, 2);
			end
			window--;
			rsp.ready <= (style == 0) ? 1'b1 : (style == 1) ? ($urandom_range(0, 2) != 0)
				: ($urandom_range(0, 3) == 0);
		end
	end

	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready))
			quiet = 0;
		else if (arst_n) quiet++;
		if (quiet >= 20000) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic send(logic [1:0] m, logic [9:0] k, logic [9:0] nk);
		@(negedge clk);
		req.valid <= 1'b1;
		req.mode <= m;
		req.key <= k;
		req.new_key <= nk;
		do @(posedge clk); while (!req.ready);
	endtask

	task automatic pause(int n);
		@(negedge clk);
		req.valid <= 1'b0;
		repeat (n) @(negedge clk);
	endtask

	task automatic write_order(logic v);
		pause(0);
		while (pending != 0) @(negedge clk);
		repeat (60) @(negedge clk);
		cfg.valid <= 1'b1;
		cfg.max_first <= v;
		do @(posedge clk); while (!cfg.ready);
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	function automatic logic [9:0] pick_key();
		return ($urandom_range(0, 9) == 0) ? 10'($urandom) : pool[$urandom_range(0, 127)];
	endfunction

	initial begin
		int burst;
		logic [1:0] m;
		req.valid = 1'b0; req.mode = MODE_QUERY; req.key = '0; req.new_key = '0;
		cfg.valid = 1'b0; cfg.max_first = 1'b0;
		foreach (pool[i]) pool[i] = 10'($urandom);
		pool[0] = 10'd0;
		pool[1] = 10'd1023;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		write_order(1'b0);

		// directed corners
		send(MODE_EXTRACT, 10'd0, 10'd0);
		send(MODE_INSERT, 10'd0, 10'd1023);
		send(MODE_INSERT, 10'd1023, 10'd0);
		send(MODE_INSERT, 10'd512, 10'd0);
		send(MODE_INSERT, 10'd0, 10'd0);
		send(MODE_QUERY, 10'd1023, 10'd0);
		send(MODE_QUERY, 10'd5, 10'd1023);
		send(MODE_REPLACE, 10'd7, 10'd9);
		send(MODE_REPLACE, 10'd0, 10'd0);
		send(MODE_REPLACE, 10'd0, 10'd1023);
		send(MODE_REPLACE, 10'd512, 10'd3);
		send(MODE_REPLACE, 10'd1023, 10'd1);
		send(MODE_EXTRACT, 10'd0, 10'd0);
		send(MODE_QUERY, 10'd0, 10'd0);
		send(MODE_INSERT, 10'd0, 10'd0);
		send(MODE_EXTRACT, 10'd0, 10'd0);
		send(MODE_EXTRACT, 10'd0, 10'd0);
		send(MODE_EXTRACT, 10'd0, 10'd0);
		send(MODE_EXTRACT, 10'd0, 10'd0);
		write_order(1'b1);

		for (int ph = 0; ph < 7; ph++) begin
			if (ph == 2) hold_req = 400;
			for (int i = 0; i < 100; i++) begin
				case (ph % 3)
					0: m = ($urandom_range(0, 9) < 8) ? MODE_INSERT : 2'($urandom);
					1: m = 2'($urandom);
					default: m = ($urandom_range(0, 9) < 6) ? MODE_EXTRACT : 2'($urandom);
				endcase
				send(m, pick_key(), pick_key());
				if (burst == 0) begin
					burst = $urandom_range(1, 20);
					pause($urandom_range(0, 6));
				end
				burst--;
			end
			write_order((ph == 0 || ph == 3 || ph == 4) ? 1'b0 : 1'b1);
		end

		pause(0);
		while (pending != 0) @(negedge clk);
		repeat (100) @(negedge clk);
		if (fails == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end
endmodule
